// ----- src/alt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_pkg
// Shared types, codes and character classes of the assembly line tokenizer.
// ----------------------------------------------------------------------------
package alt_pkg;

  // sizes
  localparam int MAX_LEXEME = 64;
  localparam int MAX_LINE   = 256;
  localparam int LEX_W      = 7;
  localparam int COL_W      = 9;
  localparam int LINE_W     = 16;
  localparam int INT_W      = 63;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic [INT_W-1:0]  INT_MAX63 = {INT_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_SAT  = {LINE_W{1'b1}};

  // scan modes
  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_STRING  = 3'd2;
  localparam logic [2:0] MODE_ASCII   = 3'd3;
  localparam logic [2:0] MODE_INTEGER = 3'd4;

  // result kinds
  localparam logic [3:0] K_NEWLINE = 4'd0;
  localparam logic [3:0] K_COMMA   = 4'd1;
  localparam logic [3:0] K_COLON   = 4'd2;
  localparam logic [3:0] K_LPAREN  = 4'd3;
  localparam logic [3:0] K_RPAREN  = 4'd4;
  localparam logic [3:0] K_STRING  = 4'd5;
  localparam logic [3:0] K_INTEGER = 4'd6;
  localparam logic [3:0] K_IDENT   = 4'd7;
  localparam logic [3:0] K_BYTE    = 4'd8;
  localparam logic [3:0] K_ERROR   = 4'd9;
  localparam logic [3:0] K_DONE    = 4'd10;

  // error codes
  localparam logic [3:0] E_BAD_CHAR     = 4'd0;
  localparam logic [3:0] E_BAD_IDENT    = 4'd1;
  localparam logic [3:0] E_BAD_INTEGER  = 4'd2;
  localparam logic [3:0] E_LIT_NEWLINE  = 4'd3;
  localparam logic [3:0] E_LIT_LONG     = 4'd4;
  localparam logic [3:0] E_NON_ASCII    = 4'd5;
  localparam logic [3:0] E_LEXEME_LONG  = 4'd6;
  localparam logic [3:0] E_LINE_LONG    = 4'd7;
  localparam logic [3:0] E_OPEN_STRING  = 4'd8;

  // characters
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // one queue entry: all results of one item
  typedef struct packed {
    logic [3:0]        kind0;
    logic [7:0]        char0;
    logic [INT_W-1:0]  int0;
    logic [LEX_W-1:0]  len0;
    logic [3:0]        err0;
    logic              has1;
    logic [3:0]        kind1;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [3:0]        kind;
    logic [7:0]        char_out;
    logic [INT_W-1:0]  int_value;
    logic [LEX_W-1:0]  lexeme_length;
    logic [3:0]        error_code;
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  column;
    logic              last;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic ident_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_DOLLAR);
  endfunction

  function automatic logic ends_integer(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_NL) || (c == CH_LPAREN) || (c == CH_COMMA);
  endfunction

  function automatic logic ends_ident(input logic [7:0] c);
    return ends_integer(c) || (c == CH_RPAREN);
  endfunction

endpackage

// ----- src/alt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_front
// Accepts source bytes, runs the scan state and packs each item's results.
// ----------------------------------------------------------------------------
module alt_front import alt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_req,
  input  logic       in_end_of_input,
  input  q_status_t  q_stat,
  output logic       push,
  output q_entry_t   push_data
);

  logic [2:0]        mode_r, mode_nxt;
  logic [LEX_W-1:0]  lex_r, lex_nxt;
  logic [INT_W-1:0]  acc_r, acc_nxt;
  logic              lit_r, lit_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              err_r, err_nxt;

  logic              accept;
  logic              have0;
  logic              fall;
  logic              col_inc;
  logic              col_clr;
  logic              lex_full;
  logic              nhas;
  logic [3:0]        nkind;
  logic [7:0]        nchar;
  logic [3:0]        nerr;
  logic [INT_W+3:0]  prod;
  logic [INT_W-1:0]  acc_dig;
  logic [7:0]        c;
  q_entry_t          e;

  assign c        = in_byte_req;
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign lex_full = lex_r >= LEX_W'(MAX_LEXEME);

  // acc * 10 + digit, saturating
  assign prod    = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + (INT_W+4)'(c[3:0]);
  assign acc_dig = (|prod[INT_W+3:INT_W]) ? INT_MAX63 : prod[INT_W-1:0];

  always_comb begin
    mode_nxt = mode_r;
    lex_nxt  = lex_r;
    acc_nxt  = acc_r;
    lit_nxt  = lit_r;
    line_nxt = line_r;
    err_nxt  = err_r;
    e        = '0;
    e.line   = line_r;
    e.col    = col_r;
    have0    = 1'b0;
    fall     = 1'b0;
    col_inc  = 1'b0;
    col_clr  = 1'b0;
    nhas     = 1'b0;
    nkind    = K_NEWLINE;
    nchar    = '0;
    nerr     = '0;

    if (!err_r) begin
      if (in_end_of_input) begin
        have0 = 1'b1;
        if (col_r != '0) begin
          e.kind0 = K_ERROR;
          e.err0  = E_LINE_LONG;
          err_nxt = 1'b1;
        end else begin
          e.kind0 = K_DONE;
        end
      end else if (col_r >= COL_W'(MAX_LINE)) begin
        have0   = 1'b1;
        e.kind0 = K_ERROR;
        e.err0  = E_LINE_LONG;
        err_nxt = 1'b1;
      end else begin
        unique case (mode_r)
          MODE_IDENT: begin
            if (ident_char(c)) begin
              have0 = 1'b1;
              if (lex_full) begin
                e.kind0 = K_ERROR;
                e.err0  = E_LEXEME_LONG;
                err_nxt = 1'b1;
              end else begin
                e.kind0 = K_BYTE;
                e.char0 = c;
                lex_nxt = lex_r + 1'b1;
                col_inc = 1'b1;
              end
            end else if (ends_ident(c)) begin
              have0    = 1'b1;
              e.kind0  = K_IDENT;
              e.len0   = lex_r;
              mode_nxt = MODE_NORMAL;
              fall     = 1'b1;
            end else begin
              have0   = 1'b1;
              e.kind0 = K_ERROR;
              e.err0  = E_BAD_IDENT;
              err_nxt = 1'b1;
            end
          end
          MODE_INTEGER: begin
            if (is_digit(c)) begin
              have0 = 1'b1;
              if (lex_full) begin
                e.kind0 = K_ERROR;
                e.err0  = E_LEXEME_LONG;
                err_nxt = 1'b1;
              end else begin
                e.kind0 = K_BYTE;
                e.char0 = c;
                lex_nxt = lex_r + 1'b1;
                acc_nxt = acc_dig;
                col_inc = 1'b1;
              end
            end else if (ends_integer(c)) begin
              have0    = 1'b1;
              e.kind0  = K_INTEGER;
              e.int0   = acc_r;
              e.len0   = lex_r;
              mode_nxt = MODE_NORMAL;
              fall     = 1'b1;
            end else begin
              have0   = 1'b1;
              e.kind0 = K_ERROR;
              e.err0  = E_BAD_INTEGER;
              err_nxt = 1'b1;
            end
          end
          MODE_STRING: begin
            have0 = 1'b1;
            if (c == CH_DQUOTE) begin
              e.kind0  = K_STRING;
              e.len0   = lex_r;
              mode_nxt = MODE_NORMAL;
              col_inc  = 1'b1;
            end else if (c == CH_NL) begin
              e.kind0 = K_ERROR;
              e.err0  = E_OPEN_STRING;
              err_nxt = 1'b1;
            end else if (lex_full) begin
              e.kind0 = K_ERROR;
              e.err0  = E_LEXEME_LONG;
              err_nxt = 1'b1;
            end else begin
              e.kind0 = K_BYTE;
              e.char0 = c;
              lex_nxt = lex_r + 1'b1;
              col_inc = 1'b1;
            end
          end
          MODE_ASCII: begin
            if (c == CH_SQUOTE) begin
              have0    = 1'b1;
              e.kind0  = K_INTEGER;
              e.int0   = acc_r;
              e.len0   = lex_r;
              mode_nxt = MODE_NORMAL;
              col_inc  = 1'b1;
            end else if (c[7]) begin
              have0   = 1'b1;
              e.kind0 = K_ERROR;
              e.err0  = E_NON_ASCII;
              err_nxt = 1'b1;
            end else if (c == CH_NL) begin
              have0   = 1'b1;
              e.kind0 = K_ERROR;
              e.err0  = E_LIT_NEWLINE;
              err_nxt = 1'b1;
            end else if (lit_r) begin
              have0   = 1'b1;
              e.kind0 = K_ERROR;
              e.err0  = E_LIT_LONG;
              err_nxt = 1'b1;
            end else begin
              lit_nxt = 1'b1;
              acc_nxt = INT_W'(c);
              col_inc = 1'b1;
            end
          end
          default: begin
            mode_nxt = MODE_NORMAL;
            fall     = 1'b1;
          end
        endcase

        // plain byte handling, also for a terminator that closed a token
        if (fall) begin
          unique case (c)
            CH_NL: begin
              nhas     = 1'b1;
              nkind    = K_NEWLINE;
              line_nxt = (line_r != LINE_SAT) ? line_r + 1'b1 : line_r;
              col_clr  = 1'b1;
            end
            CH_SP: col_inc = 1'b1;
            CH_COMMA: begin
              nhas    = 1'b1;
              nkind   = K_COMMA;
              col_inc = 1'b1;
            end
            CH_COLON: begin
              nhas    = 1'b1;
              nkind   = K_COLON;
              col_inc = 1'b1;
            end
            CH_LPAREN: begin
              nhas    = 1'b1;
              nkind   = K_LPAREN;
              col_inc = 1'b1;
            end
            CH_RPAREN: begin
              nhas    = 1'b1;
              nkind   = K_RPAREN;
              col_inc = 1'b1;
            end
            CH_DQUOTE: begin
              mode_nxt = MODE_STRING;
              lex_nxt  = '0;
              acc_nxt  = '0;
              lit_nxt  = 1'b0;
              col_inc  = 1'b1;
            end
            CH_SQUOTE: begin
              mode_nxt = MODE_ASCII;
              lex_nxt  = '0;
              acc_nxt  = '0;
              lit_nxt  = 1'b0;
              col_inc  = 1'b1;
            end
            default: begin
              priority if (is_digit(c)) begin
                mode_nxt = MODE_INTEGER;
                lex_nxt  = LEX_W'(1);
                acc_nxt  = INT_W'(c[3:0]);
                lit_nxt  = 1'b0;
                nhas     = 1'b1;
                nkind    = K_BYTE;
                nchar    = c;
                col_inc  = 1'b1;
              end else if (ident_char(c)) begin
                mode_nxt = MODE_IDENT;
                lex_nxt  = LEX_W'(1);
                acc_nxt  = '0;
                lit_nxt  = 1'b0;
                nhas     = 1'b1;
                nkind    = K_BYTE;
                nchar    = c;
                col_inc  = 1'b1;
              end else begin
                nhas    = 1'b1;
                nkind   = K_ERROR;
                nerr    = E_BAD_CHAR;
                err_nxt = 1'b1;
              end
            end
          endcase

          // a closed token takes slot 0, the terminator's result slot 1
          if (have0) begin
            e.has1  = nhas;
            e.kind1 = nkind;
          end else if (nhas) begin
            have0   = 1'b1;
            e.kind0 = nkind;
            e.char0 = nchar;
            e.err0  = nerr;
          end
        end
      end
    end

    if (col_clr) begin
      col_nxt = '0;
    end else if (col_inc) begin
      col_nxt = col_r + 1'b1;
    end else begin
      col_nxt = col_r;
    end
  end

  assign push      = accept && have0;
  assign push_data = e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      lex_r  <= '0;
      acc_r  <= '0;
      lit_r  <= 1'b0;
      col_r  <= '0;
      line_r <= '0;
      err_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      lex_r  <= lex_nxt;
      acc_r  <= acc_nxt;
      lit_r  <= lit_nxt;
      col_r  <= col_nxt;
      line_r <= line_nxt;
      err_r  <= err_nxt;
    end
  end

  // latched error silences the front
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n) err_r |-> !push)
    else $error("result pushed after latched error");

  // column never passes the line limit
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(MAX_LINE))
    else $error("column beyond line limit");

endmodule

// ----- src/alt_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_queue
// Short queue of per-item result entries between front and back.
// ----------------------------------------------------------------------------
module alt_queue import alt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  wdata,
  input  logic      pop,
  output q_entry_t  rdata,
  output q_status_t stat
);

  q_entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign rdata      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule

// ----- src/alt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_back
// Unpacks queue entries into output register results, one per unstalled cycle.
// ----------------------------------------------------------------------------
module alt_back import alt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_entry_t  head,
  input  q_status_t q_stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   res
);

  logic    out_valid_r, out_valid_nxt;
  logic    phase_r, phase_nxt;
  result_t res_r, res_nxt;
  logic    load;

  assign load = !out_valid_r || out_ready;

  always_comb begin
    pop           = 1'b0;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    if (load && !q_stat.empty) begin
      out_valid_nxt       = 1'b1;
      res_nxt.line_number = head.line;
      res_nxt.column      = head.col;
      if (!phase_r) begin
        res_nxt.kind          = head.kind0;
        res_nxt.char_out      = head.char0;
        res_nxt.int_value     = head.int0;
        res_nxt.lexeme_length = head.len0;
        res_nxt.error_code    = head.err0;
        res_nxt.last          = !head.has1;
        if (head.has1) begin
          phase_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        // second result is always a bare punctuation or newline token
        res_nxt.kind          = head.kind1;
        res_nxt.char_out      = '0;
        res_nxt.int_value     = '0;
        res_nxt.lexeme_length = '0;
        res_nxt.error_code    = '0;
        res_nxt.last          = 1'b1;
        phase_nxt             = 1'b0;
        pop                   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  // mid-entry the head entry must still sit in the queue
  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> !q_stat.empty)
    else $error("second result pending with empty queue");

endmodule

// ----- src/assembly_line_tokenizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_line_tokenizer_top
// Streams assembly source bytes in and token, lexeme byte and error items out.
// ----------------------------------------------------------------------------
// usage
//   in channel: one source byte per item (in_byte_req), or an end-of-file
//   marker (in_end_of_input). out channel: one result per item, with
//   out_last high on the final result caused by an input item.
//   an input item gives zero, one or two results; a non-space byte that
//   closes an identifier or integer also yields a punctuation/newline result.
// path and throughput
//   a result passes through the queue and then the output register after
//   its input item is accepted. one input item per cycle is taken while the
//   four-entry queue has room; the output side delivers one result per
//   cycle while out_ready is high, so items with two results drain at half
//   the input rate. the accept-to-state loop (mode update plus the 67-bit
//   x10 add of the decimal accumulator) sets the one-item-per-cycle front.
// reset
//   synchronous, active low: scanner back to normal mode, line and
//   column zero, error latch clear, queue and output register empty.
// stall
//   when out_ready is low the output register holds; the queue keeps
//   taking items until it fills, then in_ready drops.
// ----------------------------------------------------------------------------
module assembly_line_tokenizer_top import alt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // source byte channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte_req,
  input  logic              in_end_of_input,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_kind,
  output logic [7:0]        out_char_out,
  output logic [INT_W-1:0]  out_int_value,
  output logic [LEX_W-1:0]  out_lexeme_length,
  output logic [3:0]        out_error_code,
  output logic [LINE_W-1:0] out_line_number,
  output logic [COL_W-1:0]  out_column,
  output logic              out_last
);

  // front to queue
  logic      push;
  q_entry_t  push_data;
  // queue to back
  q_entry_t  head;
  q_status_t q_stat;
  logic      pop;
  result_t   res;

  // scanner: classifies each byte, owns all scan state and the error latch
  alt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_req     (in_byte_req),
    .in_end_of_input (in_end_of_input),
    .q_stat          (q_stat),
    .push            (push),
    .push_data       (push_data)
  );

  // one entry per item that has any result
  alt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_data),
    .pop   (pop),
    .rdata (head),
    .stat  (q_stat)
  );

  // serializes entries into single result items
  alt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_kind          = res.kind;
  assign out_char_out      = res.char_out;
  assign out_int_value     = res.int_value;
  assign out_lexeme_length = res.lexeme_length;
  assign out_error_code    = res.error_code;
  assign out_line_number   = res.line_number;
  assign out_column        = res.column;
  assign out_last          = res.last;

endmodule
